@@ src/plt_pkg.sv @@
`default_nettype none

package plt_pkg;

   // default sizes
   localparam int PLT_ENTRIES   = 256;
   localparam int PLT_MAX_LEVEL = 32;

   // fixed field and datapath widths (sized for the largest allowed level)
   localparam int COMP_W   = 8;
   localparam int IDX_W    = 8;
   localparam int LEVEL_W  = 7;
   localparam int PROD_W   = 14;
   localparam int SUM_W    = 16;
   localparam int SCORE_W  = 15;
   localparam int RGB_W    = 3 * COMP_W;
   localparam int NUM_COMP = 3;

   localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

   // request operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic              operation;
      logic [IDX_W-1:0]  entry_index;
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
      logic [IDX_W-1:0]  source_color;
      logic [5:0]        light_level;
   } plt_req_type;

   typedef struct packed {
      logic [IDX_W-1:0]   best_index;
      logic [SCORE_W-1:0] best_score;
   } plt_rsp_type;

   // data handed from one distance cell to the next
   typedef struct packed {
      logic                             valid;
      logic [IDX_W-1:0]                 idx;
      logic [SUM_W-1:0]                 sum;
      logic [NUM_COMP-1:0][COMP_W-1:0]  comp;
   } plt_cell_type;

endpackage

`default_nettype wire

@@ src/plt_palette_mem.sv @@
`default_nettype none

module plt_palette_mem
   import plt_pkg::*;
#(
   parameter int DEPTH = PLT_ENTRIES,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [RGB_W-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [RGB_W-1:0] rdata_ff
);

   // palette storage, contents undefined until loaded
   logic [RGB_W-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

endmodule

`default_nettype wire

@@ src/plt_cell.sv @@
`default_nettype none

module plt_cell
   import plt_pkg::*;
#(
   parameter int MAX_LEVEL = PLT_MAX_LEVEL
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load_target,
   input  wire logic [PROD_W-1:0] target_in,
   input  plt_cell_type           cell_in,
   output plt_cell_type           cell_ff
);

   localparam logic [PROD_W-1:0] ML_C = PROD_W'(MAX_LEVEL);

   logic [PROD_W-1:0] target_ff;
   logic [PROD_W-1:0] scaled;
   logic [PROD_W-1:0] diff;
   plt_cell_type      cell_in_nxt;

   // this cell's shaded target component, held for the whole scan
   always_ff @(posedge clock) begin
      if (load_target) begin
         target_ff <= target_in;
      end
   end

   // absolute difference of the scaled entry component and the target
   always_comb begin
      scaled = PROD_W'(cell_in.comp[0]) * ML_C;
      diff   = (scaled > target_ff) ? (scaled - target_ff) : (target_ff - scaled);
      cell_in_nxt         = cell_in;
      cell_in_nxt.sum     = cell_in.sum + SUM_W'(diff);
      cell_in_nxt.comp[0] = cell_in.comp[1];
      cell_in_nxt.comp[1] = cell_in.comp[2];
      cell_in_nxt.comp[2] = '0;
   end

   // hand partial sum and remaining components to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff.valid <= cell_in.valid;
      end
      cell_ff.idx  <= cell_in_nxt.idx;
      cell_ff.sum  <= cell_in_nxt.sum;
      cell_ff.comp <= cell_in_nxt.comp;
   end

endmodule

`default_nettype wire

@@ src/plt_select.sv @@
`default_nettype none

module plt_select
   import plt_pkg::*;
#(
   parameter int PALETTE_ENTRIES = PLT_ENTRIES
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  plt_cell_type cand,
   output logic        done,
   output logic        rsp_valid_ff,
   output plt_rsp_type rsp_data
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

   logic [SCORE_W-1:0] score;
   logic               take;
   logic [SCORE_W-1:0] best_ff;
   logic [IDX_W-1:0]   best_idx_ff;

   // saturate the score and keep the first smallest one
   always_comb begin
      score = (cand.sum > SUM_W'(SCORE_MAX)) ? SCORE_MAX : cand.sum[SCORE_W-1:0];
      take  = cand.valid && ((cand.idx == '0) || (score < best_ff));
      done  = cand.valid && (cand.idx == LAST_IDX);
   end

   always_ff @(posedge clock) begin
      if (take) begin
         best_ff     <= score;
         best_idx_ff <= cand.idx;
      end
   end

   // result strobe after the last entry is compared
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= done;
      end
   end

   assign rsp_data.best_index = best_idx_ff;
   assign rsp_data.best_score = best_ff;

endmodule

`default_nettype wire

@@ src/palette_light_table_match_top.sv @@
`default_nettype none
// channel      ports                         transfer
// request      start, busy, req_data         start high and busy low at a rising edge
// response     rsp_valid, rsp_data           one-cycle strobe, always taken
//
// a load request never raises busy
// a query holds busy through the source step and the scan, one palette read per cycle
// through the single memory read port, then while the three-cell distance chain drains
// rsp_valid rises at the edge busy falls; a new request may enter in that cycle
// synchronous active-high reset clears control only; palette is undefined until loaded
// the receiver cannot stall, so no result is ever held back

module palette_light_table_match_top
   import plt_pkg::*;
#(
   parameter int PALETTE_ENTRIES = PLT_ENTRIES,
   parameter int MAX_LEVEL       = PLT_MAX_LEVEL
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   start,
   output logic        busy,
   input  plt_req_type req_data,
   output logic        rsp_valid,
   output plt_rsp_type rsp_data
);

   localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam logic [AW-1:0]      LAST_ADDR = AW'(PALETTE_ENTRIES - 1);
   localparam logic [LEVEL_W-1:0] ML_C      = LEVEL_W'(MAX_LEVEL);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SRC   = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_DRAIN = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [AW-1:0]        cnt_ff, cnt_in;
   logic [LEVEL_W-1:0]   level_ff, level_in;
   logic                 src_ok_ff, src_ok_in;
   logic                 iss_ff;
   logic [AW-1:0]        iss_idx_ff;

   logic                 accept;
   logic                 mem_we;
   logic [AW-1:0]        mem_raddr;
   logic [RGB_W-1:0]     mem_rdata;
   logic [RGB_W-1:0]     src_rgb;
   logic                 issue;
   logic                 load_target;
   logic                 done;
   logic [PROD_W-1:0]    target [NUM_COMP];
   plt_cell_type         chain [NUM_COMP+1];

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // load writes go straight into the palette
   assign mem_we = accept && (req_data.operation == OP_LOAD)
                   && ({1'b0, req_data.entry_index} < (IDX_W+1)'(PALETTE_ENTRIES));

   // sequencer: source read, target setup, scan, drain
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      level_in    = level_ff;
      src_ok_in   = src_ok_ff;
      issue       = 1'b0;
      load_target = 1'b0;
      mem_raddr   = req_data.source_color[AW-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.operation == OP_QUERY)) begin
               level_in  = ({1'b0, req_data.light_level} > ML_C) ? ML_C
                           : {1'b0, req_data.light_level};
               src_ok_in = ({1'b0, req_data.source_color} < (IDX_W+1)'(PALETTE_ENTRIES));
               state_in  = ST_SRC;
            end
         end
         ST_SRC: begin
            load_target = 1'b1;
            cnt_in      = '0;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            mem_raddr = cnt_ff;
            issue     = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == LAST_ADDR) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         iss_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         iss_ff   <= issue;
      end
      level_ff   <= level_in;
      src_ok_ff  <= src_ok_in;
      iss_idx_ff <= cnt_ff;
   end

   plt_palette_mem #(
      .DEPTH (PALETTE_ENTRIES),
      .AW    (AW)
   ) u_mem (
      .clock    (clock),
      .we       (mem_we),
      .waddr    (req_data.entry_index[AW-1:0]),
      .wdata    ({req_data.red, req_data.green, req_data.blue}),
      .raddr    (mem_raddr),
      .rdata_ff (mem_rdata)
   );

   // shaded target components, taken by the cells at the end of the source step
   always_comb begin
      src_rgb = src_ok_ff ? mem_rdata : '0;
      for (int k = 0; k < NUM_COMP; k++) begin
         target[k] = PROD_W'(src_rgb[RGB_W-1-k*COMP_W -: COMP_W]) * PROD_W'(level_ff);
      end
   end

   // scanned entry enters the head of the chain
   always_comb begin
      chain[0].valid   = iss_ff;
      chain[0].idx     = IDX_W'(iss_idx_ff);
      chain[0].sum     = '0;
      chain[0].comp[0] = mem_rdata[RGB_W-1 -: COMP_W];
      chain[0].comp[1] = mem_rdata[RGB_W-1-COMP_W -: COMP_W];
      chain[0].comp[2] = mem_rdata[COMP_W-1:0];
   end

   for (genvar g = 0; g < NUM_COMP; g++) begin : g_cell
      plt_cell #(
         .MAX_LEVEL (MAX_LEVEL)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .load_target (load_target),
         .target_in   (target[g]),
         .cell_in     (chain[g]),
         .cell_ff     (chain[g+1])
      );
   end

   plt_select #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_select (
      .clock        (clock),
      .reset        (reset),
      .cand         (chain[NUM_COMP]),
      .done         (done),
      .rsp_valid_ff (rsp_valid),
      .rsp_data     (rsp_data)
   );

   // a result only follows the drain step
   a_rsp_after_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_DRAIN))
      else $error("response outside a query");

   // an accepted query raises busy
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.operation == OP_QUERY)) |=> busy)
      else $error("query did not start");

   // the scan ends after the last palette address
   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && (cnt_ff == LAST_ADDR)) |=> (state_ff == ST_DRAIN))
      else $error("scan overran the palette");

   // no palette write while a query is in flight
   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !mem_we)
      else $error("palette written during a query");

endmodule

`default_nettype wire
